// ===== hdl/ple_pkg.sv =====
package ple_pkg;

   localparam int OpcodeW   = 2;
   localparam int PositionW = 8;
   localparam int ValueW    = 32;
   localparam int OutCountW = 5;

   typedef enum logic [OpcodeW-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOCATE = 2'd2,
      OP_RANGE  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic start;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic rotate;
      logic last;
   } sts_type;

endpackage

// ===== hdl/ple_if.sv =====
interface ple_req_if;
   import ple_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OpcodeW-1:0]          opcode;
   logic [PositionW-1:0]        position;
   logic signed [ValueW-1:0]    item_value;
   logic signed [ValueW-1:0]    range_top;

   modport source (output valid, opcode, position, item_value, range_top, input ready);
   modport sink   (input valid, opcode, position, item_value, range_top, output ready);
endinterface

interface ple_rsp_if;
   import ple_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        ok;
   logic [OutCountW-1:0]        found_position;
   logic signed [ValueW-1:0]    removed_value;
   logic [OutCountW-1:0]        removed_count;
   logic [OutCountW-1:0]        list_count;

   modport source (output valid, ok, found_position, removed_value, removed_count,
                   list_count, input ready);
   modport sink   (input valid, ok, found_position, removed_value, removed_count,
                   list_count, output ready);
endinterface

// ===== hdl/ple_ctrl.sv =====
module ple_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ple_pkg::sts_type sts,
   output ple_pkg::cmd_type cmd
);
   import ple_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ROTATE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      valid_ff, valid_in;
   logic      publish;
   logic      out_free;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      publish  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               if (sts.rotate) begin
                  cmd.start = 1'b1;
                  state_in  = ST_ROTATE;
               end else begin
                  cmd.decide = 1'b1;
                  publish    = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_ROTATE: begin
            cmd.step = 1'b1;
            if (sts.last) begin
               publish  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = publish || (valid_ff && !rsp_ready);
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;

endmodule

// ===== hdl/ple_datapath.sv =====
module ple_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ple_pkg::cmd_type                  cmd,
   output ple_pkg::sts_type                  sts,
   input  logic [ple_pkg::OpcodeW-1:0]       req_opcode,
   input  logic [ple_pkg::PositionW-1:0]     req_position,
   input  logic signed [ple_pkg::ValueW-1:0] req_item_value,
   input  logic signed [ple_pkg::ValueW-1:0] req_range_top,
   output logic                              rsp_ok,
   output logic [ple_pkg::OutCountW-1:0]     rsp_found_position,
   output logic signed [ple_pkg::ValueW-1:0] rsp_removed_value,
   output logic [ple_pkg::OutCountW-1:0]     rsp_removed_count,
   output logic [ple_pkg::OutCountW-1:0]     rsp_list_count
);
   import ple_pkg::*;

   localparam int CountW = $clog2(CAPACITY + 1);
   localparam int IndexW = $clog2(CAPACITY);
   localparam int CmpW   = ((CountW > PositionW) ? CountW : PositionW) + 1;

   logic signed [ValueW-1:0] cell_ff [CAPACITY];
   logic signed [ValueW-1:0] cell_in [CAPACITY];

   opcode_type               op_ff;
   logic [PositionW-1:0]     pos_ff;
   logic signed [ValueW-1:0] val_ff;
   logic signed [ValueW-1:0] top_ff;

   logic [CountW-1:0]        count_ff, count_in;
   logic [CountW-1:0]        step_ff, len_ff, found_ff, rcnt_ff;
   logic signed [ValueW-1:0] removed_ff;

   logic                     ok_ff;
   logic [OutCountW-1:0]     found_out_ff, rcnt_out_ff, list_out_ff;
   logic signed [ValueW-1:0] removed_out_ff;

   logic [CmpW-1:0]          pos_ext, pos_m1, count_ext;
   logic                     req_ok;
   logic signed [ValueW-1:0] head;
   logic                     in_range, drop, hit;
   logic [CountW-1:0]        found_nxt, len_nxt, rcnt_nxt, len_m1, count_m1, ins_count;
   logic signed [ValueW-1:0] removed_nxt;
   logic [IndexW-1:0]        tail_idx;
   logic [31:0]              list_wide, found_wide, rcnt_wide, ins_wide;

   assign pos_ext   = CmpW'(pos_ff);
   assign pos_m1    = pos_ext - 1'b1;
   assign count_ext = CmpW'(count_ff);
   assign count_m1  = count_ff - 1'b1;
   assign ins_count = count_ff + 1'b1;

   always_comb begin
      case (op_ff)
         OP_INSERT: req_ok = (pos_ff != '0) && (pos_ext <= count_ext + 1'b1) &&
                             (count_ext < CmpW'(CAPACITY));
         OP_DELETE: req_ok = (pos_ff != '0) && (pos_ext <= count_ext);
         OP_LOCATE: req_ok = 1'b1;
         OP_RANGE:  req_ok = (count_ff != '0) && (val_ff < top_ff);
         default:   req_ok = 1'b0;
      endcase
   end

   assign sts.rotate = req_ok && (op_ff != OP_INSERT) && (count_ff != '0);
   assign sts.last   = (step_ff == count_m1);

   assign head        = cell_ff[0];
   assign in_range    = (head >= val_ff) && (head <= top_ff);
   assign drop        = ((op_ff == OP_DELETE) && (CmpW'(step_ff) == pos_m1)) ||
                        ((op_ff == OP_RANGE) && in_range);
   assign hit         = (op_ff == OP_LOCATE) && (head == val_ff) && (found_ff == '0);
   assign found_nxt   = hit ? step_ff + 1'b1 : found_ff;
   assign len_nxt     = len_ff - CountW'(drop);
   assign rcnt_nxt    = rcnt_ff + CountW'(drop);
   assign removed_nxt = ((op_ff == OP_DELETE) && drop) ? head : removed_ff;
   assign len_m1      = len_ff - 1'b1;
   assign tail_idx    = len_m1[IndexW-1:0];

   assign list_wide  = 32'(len_nxt);
   assign found_wide = 32'(found_nxt);
   assign rcnt_wide  = 32'(rcnt_nxt);
   assign ins_wide   = 32'((req_ok && (op_ff == OP_INSERT)) ? ins_count : count_ff);

   always_comb begin
      cell_in = cell_ff;
      if (cmd.decide && req_ok && (op_ff == OP_INSERT)) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (CmpW'(i) == pos_m1) begin
               cell_in[i] = val_ff;
            end else if ((i > 0) && (CmpW'(i) > pos_m1)) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end else if (cmd.step) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_in[i] = cell_ff[i + 1];
         end
         if (!drop) begin
            cell_in[tail_idx] = head;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.decide && req_ok && (op_ff == OP_INSERT)) begin
         count_in = ins_count;
      end else if (cmd.step && sts.last) begin
         count_in = len_nxt;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= opcode_type'(req_opcode);
         pos_ff <= req_position;
         val_ff <= req_item_value;
         top_ff <= req_range_top;
      end
      if (cmd.start) begin
         step_ff    <= '0;
         len_ff     <= count_ff;
         found_ff   <= '0;
         rcnt_ff    <= '0;
         removed_ff <= '0;
      end else if (cmd.step) begin
         step_ff    <= step_ff + 1'b1;
         len_ff     <= len_nxt;
         found_ff   <= found_nxt;
         rcnt_ff    <= rcnt_nxt;
         removed_ff <= removed_nxt;
      end
      if (cmd.decide) begin
         ok_ff          <= req_ok;
         found_out_ff   <= '0;
         removed_out_ff <= '0;
         rcnt_out_ff    <= '0;
         list_out_ff    <= ins_wide[OutCountW-1:0];
      end else if (cmd.step && sts.last) begin
         ok_ff          <= 1'b1;
         found_out_ff   <= (op_ff == OP_LOCATE) ? found_wide[OutCountW-1:0] : '0;
         removed_out_ff <= (op_ff == OP_DELETE) ? removed_nxt : '0;
         rcnt_out_ff    <= (op_ff == OP_RANGE) ? rcnt_wide[OutCountW-1:0] : '0;
         list_out_ff    <= list_wide[OutCountW-1:0];
      end
   end

   assign rsp_ok             = ok_ff;
   assign rsp_found_position = found_out_ff;
   assign rsp_removed_value  = removed_out_ff;
   assign rsp_removed_count  = rcnt_out_ff;
   assign rsp_list_count     = list_out_ff;

endmodule

// ===== hdl/positional_list_engine.sv =====
// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of cells. An insert,
// a refused request, or a locate on an empty list is answered from the decide state without
// rotating. Delete, locate and range delete on a non-empty list rotate the whole list once
// through the cell chain, one entry per cycle. One request is in work at a
// time; a finished response waits in its own register, and the next request beat is taken
// while it does. The cell contents are not cleared at reset; only the length is.
module positional_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   ple_req_if.sink    req_bus,
   ple_rsp_if.source  rsp_bus
);
   import ple_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_bus.opcode),
      .req_position       (req_bus.position),
      .req_item_value     (req_bus.item_value),
      .req_range_top      (req_bus.range_top),
      .rsp_ok             (rsp_bus.ok),
      .rsp_found_position (rsp_bus.found_position),
      .rsp_removed_value  (rsp_bus.removed_value),
      .rsp_removed_count  (rsp_bus.removed_count),
      .rsp_list_count     (rsp_bus.list_count)
   );

endmodule
